@@ hdl/drrt_pkg.sv @@
// Package for the damage region tracker: rectangle type, mode codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package drrt_pkg;

   typedef enum logic [2:0] {
      MODE_ADD   = 3'd0,
      MODE_CLEAR = 3'd1,
      MODE_FULL  = 3'd2,
      MODE_GROW  = 3'd3,
      MODE_HIT   = 3'd4
   } mode_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
   } rect_type;

   localparam int GROW_SIDES = 2;

   // saturate a 19-bit signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v < -19'sd32768) r = 16'sh8000;
      else if (v > 19'sd32767) r = 16'sh7FFF;
      else r = v[15:0];
      return r;
   endfunction

endpackage

@@ hdl/drrt_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface drrt_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/drrt_store.sv @@
// Rectangle store: synchronous memory, one write port, one read port, registered read.
// Depends on drrt_pkg.
`timescale 1ns / 1ps
module drrt_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  drrt_pkg::rect_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output drrt_pkg::rect_type  rd_data
);
   drrt_pkg::rect_type mem [DEPTH];
   drrt_pkg::rect_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/damage_rect_region_tracker_core.sv @@
// Damage region tracker. One transaction in gives one transaction out. The
// rectangles live in a single-port-read synchronous memory; each operation
// sweeps the stored entries one per cycle (read issue, then compare/modify and
// optional write-back of that entry), and a second sweep builds the bounding
// box reported in every result. The first sweep runs over every entry for a
// grow, a hit and an add with no match; then come the bounding sweep and
// the output stage. An add that appends first writes the new box in an
// append step, and the bounding sweep then covers one more entry; an add
// that collapses folds the stored entries and the new box into entry zero
// in a further sweep. Clear, mark full, unused codes, a decided add, a grow
// by zero or fewer pixels and a hit on a full store end the first sweep
// early; a hit otherwise sweeps on past a match. Requests are taken only in
// the idle state. The result sits in an output register; the next request
// is taken while it waits, and a new result is held back until it is consumed.
// Depends on drrt_pkg, drrt_if, drrt_store.
`timescale 1ns / 1ps
module damage_rect_region_tracker_core #(
   parameter int MAX_RECTS = 16
) (
   input  logic clock,
   input  logic reset,
   drrt_if.sink   req,
   drrt_if.source rsp
);
   localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 1);

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic signed [15:0] rect_w;
      logic signed [15:0] rect_h;
      logic signed [15:0] grow_pixels;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] bound_x;
      logic signed [15:0] bound_y;
      logic signed [15:0] bound_w;
      logic signed [15:0] bound_h;
      logic               is_empty;
      logic               is_full;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_OP, S_APPEND, S_COLLAPSE, S_BOUND, S_DONE
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   drrt_pkg::rect_type nb;
   logic [CW-1:0]      count_ff;
   logic               full_ff;
   logic [CW:0]        idx_ff;     // read index being issued
   logic               pend_ff;    // read data valid this cycle
   logic [AW-1:0]      pidx_ff;    // index of the data now returned
   logic               hit_ff;
   logic               any_ff;
   logic signed [16:0] l_ff, t_ff, r_ff, d_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   drrt_pkg::rect_type wr_data, rd_data;

   drrt_store #(.DEPTH(MAX_RECTS), .AW(AW)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign nb = '{x: req_ff.rect_x, y: req_ff.rect_y, w: req_ff.rect_w, h: req_ff.rect_h};
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // output register takes a new result when empty or being drained
   logic rsp_load;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   // edges of the stored entry and of the new box, 17 bits exact
   logic signed [16:0] ex, ey, er, ed, nx, ny, nr, nd;
   logic               cov_old, cov_new, ovl;
   logic signed [18:0] gp;
   drrt_pkg::rect_type grown;
   assign ex = 17'(rd_data.x);
   assign ey = 17'(rd_data.y);
   assign er = 17'(rd_data.x) + 17'(rd_data.w);
   assign ed = 17'(rd_data.y) + 17'(rd_data.h);
   assign nx = 17'(nb.x);
   assign ny = 17'(nb.y);
   assign nr = 17'(nb.x) + 17'(nb.w);
   assign nd = 17'(nb.y) + 17'(nb.h);
   assign cov_old = nx >= ex && ny >= ey && nr <= er && nd <= ed;
   assign cov_new = ex >= nx && ey >= ny && er <= nr && ed <= nd;
   assign ovl = ((er < nr ? er : nr) > (ex > nx ? ex : nx)) &&
                ((ed < nd ? ed : nd) > (ey > ny ? ey : ny));
   assign gp = 19'(req_ff.grow_pixels);
   assign grown.x = drrt_pkg::sat16(19'(rd_data.x) - gp);
   assign grown.y = drrt_pkg::sat16(19'(rd_data.y) - gp);
   assign grown.w = drrt_pkg::sat16(19'(rd_data.w) + gp * 19'(drrt_pkg::GROW_SIDES));
   assign grown.h = drrt_pkg::sat16(19'(rd_data.h) + gp * 19'(drrt_pkg::GROW_SIDES));

   logic issue;
   assign issue = idx_ff < (CW+1)'(count_ff);
   assign rd_addr = idx_ff[AW-1:0];

   // first sweep: when it ends and where it goes next
   drrt_pkg::mode_type op_mode;
   logic               sweep_end, op_done;
   state_type          op_next;
   assign op_mode = drrt_pkg::mode_type'(req_ff.mode);
   assign sweep_end = !pend_ff && !issue && idx_ff != '0;
   always_comb begin
      op_done = 1'b1;
      op_next = S_BOUND;
      case (op_mode)
         drrt_pkg::MODE_ADD: begin
            if (full_ff || req_ff.rect_w <= 0 || req_ff.rect_h <= 0 ||
                (pend_ff && (cov_old || cov_new))) begin
               op_done = 1'b1;
            end else if (sweep_end || count_ff == '0) begin
               op_next = (count_ff < CW'(MAX_RECTS)) ? S_APPEND : S_COLLAPSE;
            end else begin
               op_done = 1'b0;
            end
         end
         drrt_pkg::MODE_GROW: begin
            op_done = req_ff.grow_pixels <= 0 || sweep_end || count_ff == '0;
         end
         drrt_pkg::MODE_HIT: begin
            op_done = full_ff || sweep_end || count_ff == '0;
         end
         default: op_done = 1'b1;
      endcase
   end

   // bounding box accumulate helpers
   logic signed [16:0] bl, bt, br, bd;
   logic signed [18:0] bw, bh;
   always_comb begin
      bl = (!any_ff || ex < l_ff) ? ex : l_ff;
      bt = (!any_ff || ey < t_ff) ? ey : t_ff;
      br = (!any_ff || er > r_ff) ? er : r_ff;
      bd = (!any_ff || ed > d_ff) ? ed : d_ff;
      bw = 19'(r_ff) - 19'(l_ff);
      bh = 19'(d_ff) - 19'(t_ff);
   end

   // write port
   always_comb begin
      wr_en = 1'b0;
      wr_addr = pidx_ff;
      wr_data = nb;
      case (state_ff)
         S_OP: begin
            if (pend_ff && drrt_pkg::mode_type'(req_ff.mode) == drrt_pkg::MODE_GROW) begin
               wr_en = 1'b1;
               wr_data = grown;
            end else if (pend_ff && drrt_pkg::mode_type'(req_ff.mode) == drrt_pkg::MODE_ADD
                         && !cov_old && cov_new) begin
               wr_en = 1'b1;
            end
         end
         S_APPEND: begin
            wr_en = 1'b1;
            wr_addr = count_ff[AW-1:0];
         end
         S_COLLAPSE: begin
            if (!pend_ff && !issue) begin
               // all entries folded, add the new box, store entry zero
               wr_en = 1'b1;
               wr_addr = '0;
               wr_data.x = l_ff < nx ? l_ff[15:0] : nb.x;
               wr_data.y = t_ff < ny ? t_ff[15:0] : nb.y;
               wr_data.w = drrt_pkg::sat16(19'((r_ff > nr ? r_ff : nr)) -
                                           19'((l_ff < nx ? l_ff : nx)));
               wr_data.h = drrt_pkg::sat16(19'((d_ff > nd ? d_ff : nd)) -
                                           19'((t_ff < ny ? t_ff : ny)));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  req_ff <= req.payload;
                  idx_ff <= '0;
                  pend_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  any_ff <= 1'b0;
                  state_ff <= S_OP;
               end
            end
            S_OP: begin
               // sweep entries; stop early on a decided add or a hit on a full store
               pidx_ff <= idx_ff[AW-1:0];
               if (op_mode == drrt_pkg::MODE_HIT && (full_ff || (pend_ff && ovl))) begin
                  hit_ff <= 1'b1;
               end
               if (op_mode == drrt_pkg::MODE_CLEAR || op_mode == drrt_pkg::MODE_FULL) begin
                  count_ff <= '0;
                  full_ff <= (op_mode == drrt_pkg::MODE_FULL);
               end
               if (op_done) begin
                  state_ff <= op_next;
                  idx_ff <= '0;
                  pend_ff <= 1'b0;
               end else begin
                  pend_ff <= issue;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_APPEND: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_BOUND; idx_ff <= '0; pend_ff <= 1'b0;
            end
            S_COLLAPSE, S_BOUND: begin
               if (pend_ff) begin
                  l_ff <= bl; t_ff <= bt; r_ff <= br; d_ff <= bd;
                  any_ff <= 1'b1;
               end
               if (!pend_ff && !issue) begin
                  pend_ff <= 1'b0;
                  if (state_ff == S_COLLAPSE) begin
                     count_ff <= CW'(1);
                     any_ff <= 1'b0;
                     idx_ff <= '0;
                     state_ff <= S_BOUND;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  pend_ff <= issue;
                  idx_ff <= issue ? idx_ff + 1'b1 : idx_ff;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ff.hit <= hit_ff;
                  rsp_ff.bound_x <= any_ff ? l_ff[15:0] : '0;
                  rsp_ff.bound_y <= any_ff ? t_ff[15:0] : '0;
                  rsp_ff.bound_w <= any_ff ? drrt_pkg::sat16(bw) : '0;
                  rsp_ff.bound_h <= any_ff ? drrt_pkg::sat16(bh) : '0;
                  rsp_ff.is_empty <= !full_ff && count_ff == '0;
                  rsp_ff.is_full <= full_ff;
                  rsp_ff.entry_count <= 5'(count_ff);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
